/* rtl/lph_pkg.sv */
// Shared types and constants for the linear probing hash set.
// Used by the top level, the front end and the back end; depends on nothing.
package lph_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_FILLED = 2'd1,
    KIND_TOMB   = 2'd2
  } kind_e;

  localparam int unsigned CFG_W = 11;
  localparam int unsigned HOME_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned KEY_W = 64;

endpackage

/* rtl/linear_probe_hash_set.sv */
// Linear probing hash set with tombstones: insert, lookup, remove.
// Channels: request (mode_i, key_i, home_slot_i) on in_valid/in_stall,
// result (success_o, status_o, live_count_o, tombstone_total_o) on
// out_valid/out_stall, one result word per request word.
// Write the active slot count (cfg_we_i/cfg_wdata_i) only when idle; not enforced.
// A request passes through the reduction register, which subtracts the active
// count repeatedly, then the queue, then per probed slot a registered slot store
// read and an evaluation, plus a write for a store update (an insert that returns
// to an earlier tombstone rereads that slot before the write).
// The back end handles one request at a time; further requests wait in the queue.
// Reset clears counts and starts a clearing pass over the slot-kind store;
// requests queue meanwhile.
// A stalled result holds the back end. in_stall is high while the reduction
// register holds a word, which it keeps until the two-entry queue has room.
module linear_probe_hash_set import lph_pkg::*; #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [HOME_W-1:0] home_slot_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              success_o,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  live_count_o,
  output logic [CNT_W-1:0]  tombstone_total_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned AW = $clog2(SLOTS+1);

  logic [CFG_W-1:0] active_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= CFG_W'(1024);
    else if (cfg_we_i) active_q <= cfg_wdata_i;
  end

  logic q_valid, q_pop;
  logic [1:0] q_mode;
  logic [KEY_BITS-1:0] q_key;
  logic [IW-1:0] q_start;
  logic [AW-1:0] q_act;

  lph_front #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_front (
    .clk_i, .rst_ni, .active_i(active_q), .in_valid, .in_stall,
    .mode_i, .key_i, .home_slot_i, .q_valid_o(q_valid), .q_pop_i(q_pop),
    .q_mode_o(q_mode), .q_key_o(q_key), .q_start_o(q_start), .q_act_o(q_act));

  lph_back #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_mode_i(q_mode),
    .q_key_i(q_key), .q_start_i(q_start), .q_act_i(q_act), .out_valid,
    .out_stall, .success_o, .status_o, .live_count_o, .tombstone_total_o);

endmodule

/* rtl/lph_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// Standalone; no package needed.
module lph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/lph_front.sv */
// Front end: accepts requests, reduces the home slot into range and
// queues decoded words for the back end. Uses lph_pkg.
module lph_front import lph_pkg::*; #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CFG_W-1:0]         active_i,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               mode_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [HOME_W-1:0]        home_slot_i,
  output logic                     q_valid_o,
  input  logic                     q_pop_i,
  output logic [1:0]               q_mode_o,
  output logic [KEY_BITS-1:0]      q_key_o,
  output logic [$clog2(SLOTS)-1:0] q_start_o,
  output logic [$clog2(SLOTS+1)-1:0] q_act_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned AW = $clog2(SLOTS+1);

  // Effective active count, clamped to one and SLOTS.
  logic [AW-1:0] act;
  always_comb begin
    if (active_i == '0) act = AW'(1);
    else if (32'(active_i) > SLOTS) act = AW'(SLOTS);
    else act = AW'(active_i);
  end

  // Reduction stage: the home slot is at most 1023, so subtract the active
  // count repeatedly, one subtraction per cycle.
  logic             red_busy_q;
  logic [1:0]       red_mode_q;
  logic [KEY_BITS-1:0] red_key_q;
  logic [HOME_W-1:0] red_home_q;
  logic [AW-1:0]    red_act_q;

  // Two-entry queue.
  logic [1:0]          cnt_q;
  logic                wp_q, rp_q;
  logic [1:0]          fm_q [2];
  logic [KEY_BITS-1:0] fk_q [2];
  logic [IW-1:0]       fs_q [2];
  logic [AW-1:0]       fa_q [2];

  logic in_acc, red_done, push;
  assign in_stall = red_busy_q;
  assign in_acc   = in_valid && !red_busy_q;
  assign red_done = red_busy_q && (32'(red_home_q) < 32'(red_act_q));
  assign push     = red_done && (cnt_q != 2'd2);

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_mode_o  = fm_q[rp_q];
  assign q_key_o   = fk_q[rp_q];
  assign q_start_o = fs_q[rp_q];
  assign q_act_o   = fa_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_busy_q <= 1'b0;
      cnt_q <= 2'd0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      if (in_acc) begin
        red_busy_q <= 1'b1;
        red_mode_q <= mode_i;
        red_key_q  <= key_i[KEY_BITS-1:0];
        red_home_q <= home_slot_i;
        red_act_q  <= act;
      end else if (push) begin
        red_busy_q <= 1'b0;
      end else if (red_busy_q && !red_done) begin
        red_home_q <= HOME_W'(32'(red_home_q) - 32'(red_act_q));
      end
      if (push) begin
        fm_q[wp_q] <= red_mode_q;
        fk_q[wp_q] <= red_key_q;
        fs_q[wp_q] <= IW'(red_home_q);
        fa_q[wp_q] <= red_act_q;
        wp_q <= !wp_q;
      end
      if (q_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

/* rtl/lph_back.sv */
// Back end: probes the slot stores slot by slot, handling one request at a
// time, and writes results into an output register. Uses lph_pkg and lph_ram.
module lph_back import lph_pkg::*; #(
  parameter int unsigned SLOTS    = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  logic [1:0]                 q_mode_i,
  input  logic [KEY_BITS-1:0]        q_key_i,
  input  logic [$clog2(SLOTS)-1:0]   q_start_i,
  input  logic [$clog2(SLOTS+1)-1:0] q_act_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       success_o,
  output logic [1:0]                 status_o,
  output logic [CNT_W-1:0]           live_count_o,
  output logic [CNT_W-1:0]           tombstone_total_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned AW = $clog2(SLOTS+1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_WRITE, S_OUT
  } state_e;

  state_e state_q;
  logic [IW-1:0] idx_q, free_q, wad_q;
  logic [AW-1:0] act_q, n_q;
  logic [1:0] mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic free_ok_q;
  logic [1:0] wkind_q;
  logic [CNT_W-1:0] filled_q, tomb_q;
  logic ok_q;
  logic [1:0] st_q;

  logic           k_we, d_we;
  logic [IW-1:0]  k_wa, rd_a;
  logic [1:0]     k_wd, k_rd;
  logic [KEY_BITS-1:0] d_rd;

  lph_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_kind (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd),
    .raddr_i(rd_a), .rdata_o(k_rd));
  lph_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_keys (
    .clk_i, .we_i(d_we), .waddr_i(wad_q), .wdata_i(key_q),
    .raddr_i(rd_a), .rdata_o(d_rd));

  assign rd_a = idx_q;
  // Clearing pass writes empty to every slot after reset.
  assign k_we = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign k_wa = (state_q == S_CLEAR) ? idx_q : wad_q;
  assign k_wd = (state_q == S_CLEAR) ? KIND_EMPTY : wkind_q;
  assign d_we = (state_q == S_WRITE) && (wkind_q == KIND_FILLED);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  assign out_valid = (state_q == S_OUT);
  assign success_o = ok_q;
  assign status_o = st_q;
  assign live_count_o = filled_q;
  assign tombstone_total_o = tomb_q;

  logic [IW-1:0] nxt;
  assign nxt = (32'(idx_q) + 1 >= 32'(act_q)) ? '0 : IW'(32'(idx_q) + 1);
  logic hit, lap;
  assign hit = (k_rd == KIND_FILLED) && (d_rd == key_q);
  assign lap = (32'(n_q) + 1 >= 32'(act_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q <= '0;
      filled_q <= '0;
      tomb_q <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (32'(idx_q) == SLOTS - 1) begin
            state_q <= S_IDLE;
            idx_q <= '0;
          end else idx_q <= idx_q + 1'b1;
        end
        S_IDLE: begin
          if (q_valid_i) begin
            mode_q <= q_mode_i;
            key_q <= q_key_i;
            act_q <= q_act_i;
            idx_q <= q_start_i;
            n_q <= '0;
            free_ok_q <= 1'b0;
            ok_q <= 1'b0;
            if (q_mode_i == MODE_NONE) begin
              st_q <= ST_ABSENT;
              state_q <= S_OUT;
            end else if (q_mode_i == MODE_INSERT &&
                         32'(filled_q) >= 32'(q_act_i)) begin
              st_q <= ST_FULL;
              state_q <= S_OUT;
            end else begin
              st_q <= ST_ABSENT;
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_EVAL;
        S_EVAL: begin
          if (mode_q == MODE_NONE) begin
            // Revisit of the free slot: reread its kind for the tombstone count.
            state_q <= S_WRITE;
          end else begin
            // First non-filled slot of the run is the insert target.
            if (!free_ok_q && k_rd != KIND_FILLED) begin
              free_ok_q <= 1'b1;
              free_q <= idx_q;
            end
            if (hit) begin
              wad_q <= idx_q;
              priority case (mode_q)
                MODE_INSERT: begin st_q <= ST_DUP; state_q <= S_OUT; end
                MODE_LOOKUP: begin ok_q <= 1'b1; st_q <= ST_DONE; state_q <= S_OUT; end
                default: begin wkind_q <= KIND_TOMB; state_q <= S_WRITE; end
              endcase
            end else if (k_rd == KIND_EMPTY || lap) begin
              // Absent key: an insert still needs the free slot, which may
              // lie before the point where the search stopped.
              if (mode_q == MODE_INSERT) begin
                if (!free_ok_q && k_rd != KIND_FILLED) begin
                  wad_q <= idx_q;
                  wkind_q <= KIND_FILLED;
                  state_q <= S_WRITE;
                end else if (free_ok_q) begin
                  wad_q <= free_q;
                  idx_q <= free_q;
                  wkind_q <= KIND_FILLED;
                  state_q <= S_READ;
                  mode_q <= MODE_NONE;
                end else begin
                  st_q <= ST_FULL;
                  state_q <= S_OUT;
                end
              end else state_q <= S_OUT;
            end else begin
              idx_q <= nxt;
              n_q <= n_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        S_WRITE: begin
          ok_q <= 1'b1;
          st_q <= ST_DONE;
          if (wkind_q == KIND_TOMB) begin
            tomb_q <= tomb_q + 1'b1;
            if (filled_q != '0) filled_q <= filled_q - 1'b1;
          end else begin
            filled_q <= filled_q + 1'b1;
            if (k_rd == KIND_TOMB && tomb_q != '0) tomb_q <= tomb_q - 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
